/* rtl/core/rgbhsv_pkg.sv */
// Shared constants and types for the RGB to HSV converter.
package rgbhsv_pkg;

   localparam int COLOR_BITS_DEF    = 8;
   localparam int FRACTION_BITS_DEF = 16;

   // Hexcone sector, picked by which component is largest with fixed tie-breaking.
   typedef enum logic [1:0] {
      SECTOR_RED_GB   = 2'd0,
      SECTOR_GREEN    = 2'd1,
      SECTOR_RED_BG   = 2'd2,
      SECTOR_BLUE     = 2'd3
   } sector_type;

   // Pipeline depth from item accept to result strobe.
   function automatic int latency(input int fraction_bits);
      return fraction_bits + 3;
   endfunction

endpackage

/* rtl/core/rgbhsv_front.sv */
// Front stage: max, min, chroma, hexcone sector, hue numerator and denominator, registered.
module rgbhsv_front #(
   parameter int COLOR_BITS = rgbhsv_pkg::COLOR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  logic [COLOR_BITS-1:0]   red,
   input  logic [COLOR_BITS-1:0]   green,
   input  logic [COLOR_BITS-1:0]   blue,
   output logic                    valid_out,
   output logic [COLOR_BITS+2:0]   hue_num,
   output logic [COLOR_BITS+2:0]   hue_den,
   output logic [COLOR_BITS-1:0]   chroma,
   output logic [COLOR_BITS-1:0]   value
);

   localparam int HD = COLOR_BITS + 3;

   rgbhsv_pkg::sector_type sector;
   logic [COLOR_BITS-1:0]  vmax;
   logic [COLOR_BITS-1:0]  vmin;
   logic [COLOR_BITS-1:0]  diff;
   logic [HD-1:0]          d_ext;
   logic [HD-1:0]          r_ext;
   logic [HD-1:0]          g_ext;
   logic [HD-1:0]          b_ext;

   logic                   valid_ff;
   logic [HD-1:0]          num_ff, num_in;
   logic [HD-1:0]          den_ff, den_in;
   logic [COLOR_BITS-1:0]  chroma_ff;
   logic [COLOR_BITS-1:0]  value_ff;

   always_comb begin
      if (green >= blue) begin
         sector = (red >= green) ? rgbhsv_pkg::SECTOR_RED_GB : rgbhsv_pkg::SECTOR_GREEN;
      end else begin
         sector = (red >= blue) ? rgbhsv_pkg::SECTOR_RED_BG : rgbhsv_pkg::SECTOR_BLUE;
      end

      vmax = red;
      if (green > vmax) vmax = green;
      if (blue > vmax) vmax = blue;
      vmin = red;
      if (green < vmin) vmin = green;
      if (blue < vmin) vmin = blue;
      diff = vmax - vmin;

      d_ext = HD'(diff);
      r_ext = HD'(red);
      g_ext = HD'(green);
      b_ext = HD'(blue);
      den_in = (d_ext << 2) + (d_ext << 1);

      // Every term stays non-negative and below six times chroma.
      unique case (sector)
         rgbhsv_pkg::SECTOR_RED_GB: num_in = g_ext - b_ext;
         rgbhsv_pkg::SECTOR_GREEN:  num_in = (d_ext << 1) + b_ext - r_ext;
         rgbhsv_pkg::SECTOR_RED_BG: num_in = den_in - (b_ext - g_ext);
         rgbhsv_pkg::SECTOR_BLUE:   num_in = (d_ext << 2) + r_ext - g_ext;
         default:                   num_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      num_ff    <= num_in;
      den_ff    <= den_in;
      chroma_ff <= diff;
      value_ff  <= vmax;
   end

   assign valid_out = valid_ff;
   assign hue_num   = num_ff;
   assign hue_den   = den_ff;
   assign chroma    = chroma_ff;
   assign value     = value_ff;

endmodule

/* rtl/core/rgbhsv_div_cell.sv */
// One divider cell: produces one quotient bit of the hue and saturation divisions.
module rgbhsv_div_cell #(
   parameter int COLOR_BITS    = rgbhsv_pkg::COLOR_BITS_DEF,
   parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_in,
   input  logic [COLOR_BITS+3:0]   hue_p_in,
   input  logic [COLOR_BITS+2:0]   hue_den_in,
   input  logic [FRACTION_BITS:0]  hue_q_in,
   input  logic [COLOR_BITS:0]     sat_p_in,
   input  logic [COLOR_BITS-1:0]   sat_den_in,
   input  logic [FRACTION_BITS:0]  sat_q_in,
   input  logic [COLOR_BITS-1:0]   chroma_in,
   output logic                    valid_out,
   output logic [COLOR_BITS+2:0]   hue_rem_out,
   output logic [COLOR_BITS+2:0]   hue_den_out,
   output logic [FRACTION_BITS:0]  hue_q_out,
   output logic [COLOR_BITS-1:0]   sat_rem_out,
   output logic [COLOR_BITS-1:0]   sat_den_out,
   output logic [FRACTION_BITS:0]  sat_q_out,
   output logic [COLOR_BITS-1:0]   chroma_out
);

   localparam int HD = COLOR_BITS + 3;
   localparam int QB = FRACTION_BITS + 1;

   logic                   hue_ge;
   logic                   sat_ge;
   logic [HD:0]            hue_diff;
   logic [COLOR_BITS:0]    sat_diff;

   logic                   valid_ff;
   logic [HD-1:0]          hue_rem_ff, hue_rem_in;
   logic [HD-1:0]          hue_den_ff;
   logic [QB-1:0]          hue_q_ff;
   logic [COLOR_BITS-1:0]  sat_rem_ff, sat_rem_in;
   logic [COLOR_BITS-1:0]  sat_den_ff;
   logic [QB-1:0]          sat_q_ff;
   logic [COLOR_BITS-1:0]  chroma_ff;

   // The partial remainder is below twice the divisor, so one subtract step suffices.
   always_comb begin
      hue_ge     = hue_p_in >= {1'b0, hue_den_in};
      hue_diff   = hue_ge ? (hue_p_in - {1'b0, hue_den_in}) : hue_p_in;
      hue_rem_in = hue_diff[HD-1:0];
      sat_ge     = sat_p_in >= {1'b0, sat_den_in};
      sat_diff   = sat_ge ? (sat_p_in - {1'b0, sat_den_in}) : sat_p_in;
      sat_rem_in = sat_diff[COLOR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_rem_ff <= hue_rem_in;
      hue_den_ff <= hue_den_in;
      hue_q_ff   <= {hue_q_in[QB-2:0], hue_ge};
      sat_rem_ff <= sat_rem_in;
      sat_den_ff <= sat_den_in;
      sat_q_ff   <= {sat_q_in[QB-2:0], sat_ge};
      chroma_ff  <= chroma_in;
   end

   assign valid_out   = valid_ff;
   assign hue_rem_out = hue_rem_ff;
   assign hue_den_out = hue_den_ff;
   assign hue_q_out   = hue_q_ff;
   assign sat_rem_out = sat_rem_ff;
   assign sat_den_out = sat_den_ff;
   assign sat_q_out   = sat_q_ff;
   assign chroma_out  = chroma_ff;

endmodule

/* rtl/core/rgb_to_hsv_convert.sv */
// Top level of the RGB to HSV converter: front stage, divider cell chain, output stage.
//
//   Port group   Direction   Handshake          Payload
//   req_         in          start, busy        req_red, req_green, req_blue
//   rsp_         out         rsp_valid strobe   rsp_hue, rsp_saturation, rsp_value
//
// One item is accepted every cycle while busy is low; busy is high during reset
// and in the first cycle after it. Each result passes through the registered front
// stage, each of the FRACTION_BITS + 1 divider cells (one quotient bit apiece) and the
// output register before its rsp_valid strobe.
// Reset is synchronous and clears all valid flags, dropping items in flight.
// The rsp_valid strobe lasts one cycle and the receiver cannot stall it.
module rgb_to_hsv_convert #(
   parameter int COLOR_BITS    = rgbhsv_pkg::COLOR_BITS_DEF,
   parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [COLOR_BITS-1:0]     req_red,
   input  logic [COLOR_BITS-1:0]     req_green,
   input  logic [COLOR_BITS-1:0]     req_blue,
   output logic                      rsp_valid,
   output logic [FRACTION_BITS-1:0]  rsp_hue,
   output logic [FRACTION_BITS-1:0]  rsp_saturation,
   output logic [COLOR_BITS-1:0]     rsp_value
);

   localparam int HD    = COLOR_BITS + 3;
   localparam int QB    = FRACTION_BITS + 1;
   localparam int CELLS = FRACTION_BITS + 1;

   logic                   busy_ff;
   logic                   accept;

   logic                   f_valid;
   logic [HD-1:0]          f_num;
   logic [HD-1:0]          f_den;
   logic [COLOR_BITS-1:0]  f_chroma;
   logic [COLOR_BITS-1:0]  f_value;

   logic                   c_valid   [0:CELLS-1];
   logic [HD-1:0]          c_hue_rem [0:CELLS-1];
   logic [HD-1:0]          c_hue_den [0:CELLS-1];
   logic [QB-1:0]          c_hue_q   [0:CELLS-1];
   logic [COLOR_BITS-1:0]  c_sat_rem [0:CELLS-1];
   logic [COLOR_BITS-1:0]  c_sat_den [0:CELLS-1];
   logic [QB-1:0]          c_sat_q   [0:CELLS-1];
   logic [COLOR_BITS-1:0]  c_chroma  [0:CELLS-1];

   logic                      rsp_valid_ff;
   logic [FRACTION_BITS-1:0]  rsp_hue_ff, rsp_hue_in;
   logic [FRACTION_BITS-1:0]  rsp_sat_ff, rsp_sat_in;
   logic [COLOR_BITS-1:0]     rsp_value_ff;
   logic [QB-1:0]             sat_fixed;

   assign accept = start && !busy_ff;

   rgbhsv_front #(
      .COLOR_BITS(COLOR_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .valid_in (accept),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .valid_out(f_valid),
      .hue_num  (f_num),
      .hue_den  (f_den),
      .chroma   (f_chroma),
      .value    (f_value)
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic                   valid_i;
      logic [HD:0]            hue_p_i;
      logic [HD-1:0]          hue_den_i;
      logic [QB-1:0]          hue_q_i;
      logic [COLOR_BITS:0]    sat_p_i;
      logic [COLOR_BITS-1:0]  sat_den_i;
      logic [QB-1:0]          sat_q_i;
      logic [COLOR_BITS-1:0]  chroma_i;

      if (i == 0) begin : g_head
         // Saturation numerator is chroma, never above value, so the first bit is the integer bit.
         assign valid_i   = f_valid;
         assign hue_p_i   = {1'b0, f_num};
         assign hue_den_i = f_den;
         assign hue_q_i   = '0;
         assign sat_p_i   = {1'b0, f_chroma};
         assign sat_den_i = f_value;
         assign sat_q_i   = '0;
         assign chroma_i  = f_chroma;
      end else begin : g_link
         assign valid_i   = c_valid[i-1];
         assign hue_p_i   = {c_hue_rem[i-1], 1'b0};
         assign hue_den_i = c_hue_den[i-1];
         assign hue_q_i   = c_hue_q[i-1];
         assign sat_p_i   = {c_sat_rem[i-1], 1'b0};
         assign sat_den_i = c_sat_den[i-1];
         assign sat_q_i   = c_sat_q[i-1];
         assign chroma_i  = c_chroma[i-1];
      end

      rgbhsv_div_cell #(
         .COLOR_BITS   (COLOR_BITS),
         .FRACTION_BITS(FRACTION_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .valid_in   (valid_i),
         .hue_p_in   (hue_p_i),
         .hue_den_in (hue_den_i),
         .hue_q_in   (hue_q_i),
         .sat_p_in   (sat_p_i),
         .sat_den_in (sat_den_i),
         .sat_q_in   (sat_q_i),
         .chroma_in  (chroma_i),
         .valid_out  (c_valid[i]),
         .hue_rem_out(c_hue_rem[i]),
         .hue_den_out(c_hue_den[i]),
         .hue_q_out  (c_hue_q[i]),
         .sat_rem_out(c_sat_rem[i]),
         .sat_den_out(c_sat_den[i]),
         .sat_q_out  (c_sat_q[i]),
         .chroma_out (c_chroma[i])
      );
   end

   // The chain divides chroma * 2^F by value; subtracting chroma from the
   // dividend lowers the quotient by one exactly when the remainder is below chroma.
   always_comb begin
      sat_fixed = c_sat_q[CELLS-1] - QB'(c_sat_rem[CELLS-1] < c_chroma[CELLS-1]);
      if (c_sat_den[CELLS-1] == '0) begin
         rsp_sat_in = '0;
      end else begin
         rsp_sat_in = sat_fixed[FRACTION_BITS-1:0];
      end
      if (c_hue_den[CELLS-1] == '0) begin
         rsp_hue_in = '0;
      end else begin
         rsp_hue_in = c_hue_q[CELLS-1][FRACTION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= c_valid[CELLS-1];
      end
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_value_ff <= c_sat_den[CELLS-1];
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_value      = rsp_value_ff;

endmodule

/* rtl/core/rgbhsv_checker.sv */
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgbhsv_checker #(
   parameter int COLOR_BITS    = rgbhsv_pkg::COLOR_BITS_DEF,
   parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [COLOR_BITS-1:0]     req_red,
   input logic [COLOR_BITS-1:0]     req_green,
   input logic [COLOR_BITS-1:0]     req_blue,
   input logic                      rsp_valid,
   input logic [FRACTION_BITS-1:0]  rsp_hue,
   input logic [FRACTION_BITS-1:0]  rsp_saturation,
   input logic [COLOR_BITS-1:0]     rsp_value
);

   localparam int LAT = rgbhsv_pkg::latency(FRACTION_BITS);

   logic black_in;
   assign black_in = (req_red == '0) && (req_green == '0) && (req_blue == '0);

   // Once out of reset the block takes an item every cycle.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy raised outside of reset");

   // Every accepted item produces its result after the fixed pipeline depth.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing after accepted item");

   // No result appears without an item accepted the pipeline depth earlier.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LAT !rsp_valid)
      else $error("result strobe without accepted item");

   // A black pixel gives zero hue, saturation and value.
   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && black_in) |-> ##LAT
         (rsp_hue == '0 && rsp_saturation == '0 && rsp_value == '0))
      else $error("black pixel converted to nonzero result");

endmodule

bind rgb_to_hsv_convert rgbhsv_checker #(
   .COLOR_BITS   (COLOR_BITS),
   .FRACTION_BITS(FRACTION_BITS)
) u_rgbhsv_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_red       (req_red),
   .req_green     (req_green),
   .req_blue      (req_blue),
   .rsp_valid     (rsp_valid),
   .rsp_hue       (rsp_hue),
   .rsp_saturation(rsp_saturation),
   .rsp_value     (rsp_value)
);
